// ----- design/pcap_pkg.sv -----
package pcap_pkg;

	localparam int unsigned DIM_W = 11;
	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PIXEL_W = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [DIM_W-1:0] LINE_WIDTH_RST = 11'd640;
	localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd480;

	typedef struct packed {
		logic vsync;
		logic pclk;
		logic [BYTE_W-1:0] data_byte;
	} sample_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] pixel;
		logic [DIM_W-1:0] column;
		logic [DIM_W-1:0] row;
		logic line_last;
		logic frame_last;
	} pixel_beat_t;

	typedef struct packed {
		logic [DIM_W-1:0] line_width;
		logic [DIM_W-1:0] frame_height;
	} cfg_t;

endpackage

// ----- design/pcap_sample_if.sv -----
interface pcap_sample_if;
	logic valid;
	logic ready;
	logic vsync;
	logic pclk;
	logic [pcap_pkg::BYTE_W-1:0] data_byte;

	modport source (output valid, output vsync, output pclk, output data_byte, input ready);
	modport sink (input valid, input vsync, input pclk, input data_byte, output ready);
endinterface

// ----- design/pcap_pixel_if.sv -----
interface pcap_pixel_if;
	logic valid;
	logic ready;
	logic [pcap_pkg::PIXEL_W-1:0] pixel;
	logic [pcap_pkg::DIM_W-1:0] column;
	logic [pcap_pkg::DIM_W-1:0] row;
	logic line_last;
	logic frame_last;

	modport source (output valid, output pixel, output column, output row,
		output line_last, output frame_last, input ready);
	modport sink (input valid, input pixel, input column, input row,
		input line_last, input frame_last, output ready);
endinterface

// ----- design/pcap_sample_reg.sv -----
module pcap_sample_reg (
	input  logic clk,
	input  logic arst_n,
	pcap_sample_if.sink samples,
	output pcap_pkg::sample_t sample,
	output logic sample_valid,
	input  logic take
);
	logic valid_s1;
	pcap_pkg::sample_t sample_s1;
	logic load;

	// register holds one beat; refills as the capture stage consumes it
	assign samples.ready = !valid_s1 || take;
	assign load = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sample_s1 <= '{vsync: samples.vsync, pclk: samples.pclk,
				data_byte: samples.data_byte};
		end
	end

	assign sample = sample_s1;
	assign sample_valid = valid_s1;
endmodule

// ----- design/pcap_capture.sv -----
module pcap_capture (
	input  logic clk,
	input  logic arst_n,
	input  pcap_pkg::cfg_t cfg,
	input  pcap_pkg::sample_t sample,
	input  logic sample_valid,
	output logic take,
	pcap_pixel_if.source pixels
);
	localparam logic [1:0] FP_WAIT_HIGH = 2'd0;
	localparam logic [1:0] FP_WAIT_LOW = 2'd1;
	localparam logic [1:0] FP_CAPTURE = 2'd2;

	localparam logic [1:0] BP_LOW_BYTE = 2'd0;
	localparam logic [1:0] BP_WAIT_HIGH1 = 2'd1;
	localparam logic [1:0] BP_HIGH_BYTE = 2'd2;
	localparam logic [1:0] BP_EMIT = 2'd3;

	localparam int unsigned CNT_W = pcap_pkg::DIM_W + 1;

	logic [1:0] frame_phase_q, frame_phase_d;
	logic [1:0] byte_phase_q, byte_phase_d;
	logic [pcap_pkg::BYTE_W-1:0] low_byte_q, low_byte_d;
	logic [pcap_pkg::BYTE_W-1:0] high_byte_q, high_byte_d;
	logic [pcap_pkg::DIM_W-1:0] column_q, column_d;
	logic [pcap_pkg::DIM_W-1:0] row_q, row_d;
	logic emit;
	logic eol, eof;
	logic [CNT_W-1:0] column_inc, row_inc;
	logic out_valid_q;
	pcap_pkg::pixel_beat_t out_q;

	// a beat is taken when the result register is free or draining
	assign take = sample_valid && (!out_valid_q || pixels.ready);

	// end of line and frame compares; a size of zero acts as one
	assign column_inc = {1'b0, column_q} + CNT_W'(1);
	assign row_inc = {1'b0, row_q} + CNT_W'(1);
	assign eol = column_inc >= {1'b0, cfg.line_width};
	assign eof = eol && (row_inc >= {1'b0, cfg.frame_height});

	// frame and byte sequencing for one sample
	always_comb begin
		frame_phase_d = frame_phase_q;
		byte_phase_d = byte_phase_q;
		low_byte_d = low_byte_q;
		high_byte_d = high_byte_q;
		column_d = column_q;
		row_d = row_q;
		emit = 1'b0;
		case (frame_phase_q)
			FP_WAIT_LOW: begin
				if (!sample.vsync) begin
					frame_phase_d = FP_CAPTURE;
					byte_phase_d = BP_LOW_BYTE;
					column_d = '0;
					row_d = '0;
				end
			end
			FP_CAPTURE: begin
				case (byte_phase_q)
					BP_LOW_BYTE: begin
						if (!sample.pclk) begin
							low_byte_d = sample.data_byte;
							byte_phase_d = BP_WAIT_HIGH1;
						end
					end
					BP_WAIT_HIGH1: begin
						if (sample.pclk) begin
							byte_phase_d = BP_HIGH_BYTE;
						end
					end
					BP_HIGH_BYTE: begin
						if (!sample.pclk) begin
							high_byte_d = sample.data_byte;
							byte_phase_d = BP_EMIT;
						end
					end
					BP_EMIT: begin
						if (sample.pclk) begin
							emit = 1'b1;
							byte_phase_d = BP_LOW_BYTE;
							if (eof) begin
								column_d = '0;
								row_d = '0;
								frame_phase_d = FP_WAIT_HIGH;
							end else if (eol) begin
								column_d = '0;
								row_d = row_inc[pcap_pkg::DIM_W-1:0];
							end else begin
								column_d = column_inc[pcap_pkg::DIM_W-1:0];
							end
						end
					end
					default: ;
				endcase
			end
			default: begin
				frame_phase_d = sample.vsync ? FP_WAIT_LOW : FP_WAIT_HIGH;
			end
		endcase
	end

	// capture state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase_q <= FP_WAIT_HIGH;
			byte_phase_q <= BP_LOW_BYTE;
			low_byte_q <= '0;
			high_byte_q <= '0;
			column_q <= '0;
			row_q <= '0;
		end else if (take) begin
			frame_phase_q <= frame_phase_d;
			byte_phase_q <= byte_phase_d;
			low_byte_q <= low_byte_d;
			high_byte_q <= high_byte_d;
			column_q <= column_d;
			row_q <= row_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && emit) begin
			out_valid_q <= 1'b1;
		end else if (pixels.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_q <= '{pixel: {high_byte_q, low_byte_q}, column: column_q, row: row_q,
				line_last: eol, frame_last: eof};
		end
	end

	assign pixels.valid = out_valid_q;
	assign pixels.pixel = out_q.pixel;
	assign pixels.column = out_q.column;
	assign pixels.row = out_q.row;
	assign pixels.line_last = out_q.line_last;
	assign pixels.frame_last = out_q.frame_last;
endmodule

// ----- design/parallel_camera_pixel_capture.sv -----
// channel   dir  beat payload
// samples   in   vsync, pclk, data_byte (one pin sample per beat)
// pixels    out  pixel, column, row, line_last, frame_last
// cfg       in   cfg_wr_en, cfg_index, cfg_data (0 line_width, 1 frame_height)
//
// one sample beat per cycle while samples do not stall; a sample passes the input
// register and the capture logic, which loads each pixel into the result register.
// arst_n clears the control state and loads the sizes with 640 by 480.
// a pixel waiting in the result register still lets one more sample in;
// samples stall only while that sample and the pixel both wait.
module parallel_camera_pixel_capture (
	input  logic clk,
	input  logic arst_n,
	pcap_sample_if.sink samples,
	pcap_pixel_if.source pixels,
	input  logic cfg_wr_en,
	input  logic [pcap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pcap_pkg::DIM_W-1:0] cfg_data
);
	pcap_pkg::cfg_t cfg_q;
	pcap_pkg::sample_t sample;
	logic sample_valid;
	logic take;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_width <= pcap_pkg::LINE_WIDTH_RST;
			cfg_q.frame_height <= pcap_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				pcap_pkg::REG_LINE_WIDTH: cfg_q.line_width <= cfg_data;
				pcap_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data;
				default: ;
			endcase
		end
	end

	pcap_sample_reg u_sample_reg (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.sample(sample),
		.sample_valid(sample_valid),
		.take(take)
	);

	pcap_capture u_capture (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.sample(sample),
		.sample_valid(sample_valid),
		.take(take),
		.pixels(pixels)
	);
endmodule
